/* rtl/core/lkvc_pkg.sv */
// Shared types and constants for the LRU key/value cache.
`timescale 1ns / 1ps

package lkvc_pkg;

    // Reset value of the active entry limit register.
    localparam logic [3:0] ACTIVE_RESET = 4'd5;

    // Operation codes carried on func.
    typedef enum logic {
        FUNC_GET = 1'b0,
        FUNC_PUT = 1'b1
    } cache_func_t;

    // Per-operation control broadcast from the sequencer to every cell.
    typedef struct packed {
        logic cmp;       // compare phase: cells latch their key match
        logic update;    // update phase: cells shift or hold
        logic hit;       // key found somewhere in the row
        logic put_miss;  // put whose key is absent: insert at the head
        logic evict;     // insert drops the last valid entry
    } lkvc_ctl_t;

endpackage

/* rtl/core/lkvc_cell.sv */
// One recency-ordered cache cell: key, value, valid and match flag.
`timescale 1ns / 1ps

module lkvc_cell
    import lkvc_pkg::*;
#(
    parameter int KEY_BITS   = 64,
    parameter int VALUE_BITS = 32
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  lkvc_ctl_t             ctl,
    input  logic [KEY_BITS-1:0]   op_key,
    // from the more recent neighbor
    input  logic                  prev_valid,
    input  logic [KEY_BITS-1:0]   prev_key,
    input  logic [VALUE_BITS-1:0] prev_value,
    input  logic                  prev_last,
    // from the less recent neighbor
    input  logic                  up_valid,
    input  logic                  up_hit,
    input  logic [VALUE_BITS-1:0] up_value,
    input  logic [KEY_BITS-1:0]   up_evkey,
    // to the neighbors
    output logic                  valid,
    output logic [KEY_BITS-1:0]   key,
    output logic [VALUE_BITS-1:0] value,
    output logic                  last,
    output logic                  dn_hit,
    output logic [VALUE_BITS-1:0] dn_value,
    output logic [KEY_BITS-1:0]   dn_evkey
);

    logic                  valid_reg;
    logic                  valid_next;
    logic                  match_reg;
    logic                  match_next;
    logic [KEY_BITS-1:0]   key_reg;
    logic [KEY_BITS-1:0]   key_next;
    logic [VALUE_BITS-1:0] value_reg;
    logic [VALUE_BITS-1:0] value_next;
    logic                  shift;

    assign valid = valid_reg;
    assign key   = key_reg;
    assign value = value_reg;
    assign last  = valid_reg && !up_valid;

    // hit, hit value and victim key ripple toward the head
    assign dn_hit   = up_hit | match_reg;
    assign dn_value = up_value | (match_reg ? value_reg : '0);
    assign dn_evkey = up_evkey | (last ? key_reg : '0);

    // hit: cells from the head down to the hit cell move back one place; put miss: every cell moves back one place
    assign shift = ctl.update && ((ctl.hit && dn_hit) || ctl.put_miss);

    always_comb
    begin
        match_next = match_reg;
        valid_next = valid_reg;
        key_next   = key_reg;
        value_next = value_reg;
        if (ctl.cmp)
        begin
            match_next = valid_reg && (key_reg == op_key);
        end
        if (shift)
        begin
            key_next   = prev_key;
            value_next = prev_value;
            if (ctl.put_miss)
            begin
                // the victim is not carried into this cell
                valid_next = prev_valid && !(ctl.evict && prev_last);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            match_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            match_reg <= match_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg   <= key_next;
        value_reg <= value_next;
    end

endmodule

/* rtl/core/lru_key_value_cache_top.sv */
// Top level of the LRU key/value cache: sequencer, limit register, cell row.
`timescale 1ns / 1ps

// Fully associative LRU key/value cache built as a row of ENTRIES cells kept
// in recency order: cell 0 holds the most recent entry and the valid cells
// always form an unbroken run from cell 0. A word is taken at a rising edge
// with start high and busy low; busy then stays high through the compare
// state, which latches the key compare in every cell, and the update state,
// which shifts the row and registers the result. The result is shown for
// exactly one cycle with done high, starting the cycle after the update;
// the receiver cannot stall it, and start may be raised again in
// that same cycle. The hit, hit value and victim key ripple through the row
// in the update cycle, which sets the clock period for large ENTRIES.
// cfg_wr_data sets the active entry limit (0 acts as 1, above ENTRIES acts
// as ENTRIES); write it only while busy and done are low.

module lru_key_value_cache_top
    import lkvc_pkg::*;
#(
    parameter int ENTRIES    = 8,
    parameter int KEY_BITS   = 64,
    parameter int VALUE_BITS = 32
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  logic [3:0]            cfg_wr_data,
    input  logic                  start,
    output logic                  busy,
    input  logic                  func,
    input  logic [KEY_BITS-1:0]   key_tag,
    input  logic [VALUE_BITS-1:0] put_value,
    output logic                  done,
    output logic                  hit,
    output logic [31:0]           read_value,
    output logic                  evicted,
    output logic [KEY_BITS-1:0]   evicted_key
);

    localparam int OCC_W = $clog2(ENTRIES + 1);
    localparam int CMP_W = OCC_W + 4;

    // one-hot sequencer states
    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_CMP  = 3'b010,
        ST_UPD  = 3'b100
    } state_t;

    state_t                state_reg;
    state_t                state_next;

    // captured word
    logic                  func_reg;
    logic [KEY_BITS-1:0]   op_key_reg;
    logic [VALUE_BITS-1:0] op_value_reg;

    logic [3:0]            active_reg;
    logic [OCC_W-1:0]      occ_reg;
    logic [OCC_W-1:0]      occ_next;

    // result registers
    logic                  done_reg;
    logic                  hit_reg;
    logic [31:0]           read_value_reg;
    logic [31:0]           read_value_next;
    logic                  evicted_reg;
    logic [KEY_BITS-1:0]   evicted_key_reg;

    logic                  accept;
    logic                  row_hit;
    logic                  put_miss;
    logic                  evict;
    logic [CMP_W-1:0]      limit;
    logic [CMP_W-1:0]      occ_ext;
    lkvc_ctl_t             ctl;

    // cell row wiring
    logic [ENTRIES-1:0]    valid_w;
    logic [ENTRIES-1:0]    last_w;
    logic [ENTRIES-1:0]    hit_w;
    logic [KEY_BITS-1:0]   key_w     [ENTRIES];
    logic [VALUE_BITS-1:0] value_w   [ENTRIES];
    logic [VALUE_BITS-1:0] dvalue_w  [ENTRIES];
    logic [KEY_BITS-1:0]   devkey_w  [ENTRIES];
    logic [VALUE_BITS-1:0] head_value;

    assign accept = start && (state_reg == ST_IDLE);
    assign busy   = (state_reg != ST_IDLE);

    // ---------------------------------------------------------------
    // Sequencer
    // ---------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (accept) state_next = ST_CMP;
            ST_CMP:  state_next = ST_UPD;
            ST_UPD:  state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // ---------------------------------------------------------------
    // Operation decode in the update cycle
    // ---------------------------------------------------------------
    assign row_hit  = hit_w[0];
    assign put_miss = (func_reg == FUNC_PUT) && !row_hit;
    assign occ_ext  = {4'b0, occ_reg};

    // clamp the limit into 1..ENTRIES
    always_comb
    begin
        limit = {{OCC_W{1'b0}}, active_reg};
        priority if (limit == '0)
            limit = CMP_W'(1);
        else if (limit > CMP_W'(ENTRIES))
            limit = CMP_W'(ENTRIES);
    end

    assign evict = put_miss && (occ_ext >= limit);

    assign ctl.cmp      = (state_reg == ST_CMP);
    assign ctl.update   = (state_reg == ST_UPD);
    assign ctl.hit      = row_hit;
    assign ctl.put_miss = put_miss;
    assign ctl.evict    = evict;

    // occupancy only grows on an insert that evicts nothing
    always_comb
    begin
        occ_next = occ_reg;
        if (ctl.update && put_miss && !evict)
            occ_next = occ_reg + OCC_W'(1);
    end

    // new head entry: put stores its word, get hit moves the found value
    assign head_value = (func_reg == FUNC_PUT) ? op_value_reg : dvalue_w[0];

    // ---------------------------------------------------------------
    // Cell row
    // ---------------------------------------------------------------
    for (genvar gi = 0; gi < ENTRIES; gi++)
    begin : g_cell
        logic                  p_valid;
        logic [KEY_BITS-1:0]   p_key;
        logic [VALUE_BITS-1:0] p_value;
        logic                  p_last;
        logic                  u_valid;
        logic                  u_hit;
        logic [VALUE_BITS-1:0] u_value;
        logic [KEY_BITS-1:0]   u_evkey;

        if (gi == 0)
        begin : g_head
            assign p_valid = 1'b1;
            assign p_key   = op_key_reg;
            assign p_value = head_value;
            assign p_last  = 1'b0;
        end
        else
        begin : g_body
            assign p_valid = valid_w[gi-1];
            assign p_key   = key_w[gi-1];
            assign p_value = value_w[gi-1];
            assign p_last  = last_w[gi-1];
        end

        if (gi == ENTRIES - 1)
        begin : g_tail
            assign u_valid = 1'b0;
            assign u_hit   = 1'b0;
            assign u_value = '0;
            assign u_evkey = '0;
        end
        else
        begin : g_inner
            assign u_valid = valid_w[gi+1];
            assign u_hit   = hit_w[gi+1];
            assign u_value = dvalue_w[gi+1];
            assign u_evkey = devkey_w[gi+1];
        end

        lkvc_cell #(
            .KEY_BITS   (KEY_BITS),
            .VALUE_BITS (VALUE_BITS)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctl        (ctl),
            .op_key     (op_key_reg),
            .prev_valid (p_valid),
            .prev_key   (p_key),
            .prev_value (p_value),
            .prev_last  (p_last),
            .up_valid   (u_valid),
            .up_hit     (u_hit),
            .up_value   (u_value),
            .up_evkey   (u_evkey),
            .valid      (valid_w[gi]),
            .key        (key_w[gi]),
            .value      (value_w[gi]),
            .last       (last_w[gi]),
            .dn_hit     (hit_w[gi]),
            .dn_value   (dvalue_w[gi]),
            .dn_evkey   (devkey_w[gi])
        );
    end

    // read value is reported at 32 bits
    if (VALUE_BITS >= 32)
    begin : g_rv_cut
        assign read_value_next = dvalue_w[0][31:0];
    end
    else
    begin : g_rv_ext
        assign read_value_next = {{(32-VALUE_BITS){1'b0}}, dvalue_w[0]};
    end

    // ---------------------------------------------------------------
    // Registers
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            active_reg <= ACTIVE_RESET;
            occ_reg    <= '0;
            done_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            occ_reg   <= occ_next;
            done_reg  <= ctl.update;
            if (cfg_wr_en)
                active_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            func_reg     <= func;
            op_key_reg   <= key_tag;
            op_value_reg <= put_value;
        end
        if (ctl.update)
        begin
            hit_reg         <= row_hit;
            read_value_reg  <= ((func_reg == FUNC_GET) && row_hit) ? read_value_next : '0;
            evicted_reg     <= evict;
            evicted_key_reg <= evict ? devkey_w[0] : '0;
        end
    end

    assign done        = done_reg;
    assign hit         = hit_reg;
    assign read_value  = read_value_reg;
    assign evicted     = evicted_reg;
    assign evicted_key = evicted_key_reg;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    a_done_after_update: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg == ST_UPD))
        else $error("done without an update cycle");

    a_accept_to_cmp: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (state_reg == ST_CMP))
        else $error("accepted word did not enter compare");

    a_valid_run: assert property (@(posedge clk) disable iff (!rst_n)
        ((valid_w & (valid_w + ENTRIES'(1))) == '0)
        && ($countones(valid_w) == int'(occ_reg)))
        else $error("valid cells not a run from the head matching occupancy");

    a_evict_not_hit: assert property (@(posedge clk) disable iff (!rst_n)
        (done && evicted) |-> !hit)
        else $error("eviction reported on a hit");

    a_occ_limit: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.update && evict) |=> $stable(occ_reg))
        else $error("occupancy changed on an evicting insert");

endmodule

/* dv/tb.sv */
// Self-checking testbench for the LRU key/value cache top level.
`timescale 1ns / 1ps

import lkvc_pkg::*;

// Recency-ordered shadow of the cache plus the queue of expected words.
class lru_scoreboard;
    typedef struct {
        logic [63:0] key;
        logic [31:0] value;
    } slot_t;

    typedef struct packed {
        logic        hit;
        logic [31:0] read_value;
        logic        evicted;
        logic [63:0] evicted_key;
    } lookup_t;

    slot_t      recency[$];     // index 0 is the most recent entry
    lookup_t    pending_lookups[$];
    logic [3:0] active_reg;
    int         errors;
    int         words_checked;
    int         hits_seen;
    int         evictions_seen;

    function new();
        active_reg     = ACTIVE_RESET;
        errors         = 0;
        words_checked  = 0;
        hits_seen      = 0;
        evictions_seen = 0;
    endfunction

    function void set_limit(logic [3:0] value);
        active_reg = value;
    endfunction

    function int outstanding();
        return pending_lookups.size();
    endfunction

    // Work out the result of one accepted word and update the shadow.
    function void note_input(logic func, logic [63:0] key, logic [31:0] value);
        int      found;
        int      lim;
        slot_t   s;
        lookup_t r;
        found = -1;
        r     = '0;
        foreach (recency[i])
            if (recency[i].key == key)
                found = i;
        // Limit clamps to 1..8
        lim = (active_reg < 4'd1) ? 1 : ((active_reg > 4'd8) ? 8 : int'(active_reg));
        if (found >= 0)
        begin
            r.hit = 1'b1;
            s     = recency[found];
            if (func == FUNC_GET)
                r.read_value = s.value;
            else
                s.value = value;
            recency.delete(found);
            recency.insert(0, s);
        end
        else if (func == FUNC_PUT)
        begin
            // Occupancy above a lowered limit still drops only one entry
            if (recency.size() >= lim)
            begin
                r.evicted     = 1'b1;
                r.evicted_key = recency[$].key;
                recency.delete(recency.size() - 1);
            end
            s.key   = key;
            s.value = value;
            recency.insert(0, s);
        end
        pending_lookups.push_back(r);
    endfunction

    function void check_result(logic hit, logic [31:0] read_value, logic evicted,
                               logic [63:0] evicted_key);
        lookup_t exp_r;
        if (pending_lookups.size() == 0)
        begin
            $error("result word with no expected word waiting");
            errors++;
            return;
        end
        exp_r = pending_lookups.pop_front();
        words_checked++;
        if (exp_r.hit)
            hits_seen++;
        if (exp_r.evicted)
            evictions_seen++;
        if (hit !== exp_r.hit)
        begin
            $error("hit: expected %0d, got %0d", exp_r.hit, hit);
            errors++;
        end
        if (read_value !== exp_r.read_value)
        begin
            $error("read_value: expected %h, got %h", exp_r.read_value, read_value);
            errors++;
        end
        if (evicted !== exp_r.evicted)
        begin
            $error("evicted: expected %0d, got %0d", exp_r.evicted, evicted);
            errors++;
        end
        if (evicted_key !== exp_r.evicted_key)
        begin
            $error("evicted_key: expected %h, got %h", exp_r.evicted_key, evicted_key);
            errors++;
        end
    endfunction
endclass

module tb;

    localparam int KEY_W      = 64;
    localparam int VAL_W      = 32;
    localparam int IDLE_LIMIT = 500;   // cycles with no accept and no result
    localparam int PHASE_WORDS = 65;   // random words per limit setting
    localparam int POOL_SIZE  = 16;

    logic             clk;
    logic             rst_n;
    logic             cfg_wr_en;
    logic [3:0]       cfg_wr_data;
    logic             start;
    logic             busy;
    logic             func;
    logic [KEY_W-1:0] key_tag;
    logic [VAL_W-1:0] put_value;
    logic             done;
    logic             hit;
    logic [31:0]      read_value;
    logic             evicted;
    logic [KEY_W-1:0] evicted_key;

    lru_scoreboard sb;
    int            idle_cycles;
    int            words_sent;
    int            limit_writes;
    logic [63:0]   key_pool [POOL_SIZE];

    lru_key_value_cache_top #(
        .ENTRIES    (8),
        .KEY_BITS   (KEY_W),
        .VALUE_BITS (VAL_W)
    ) u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .start       (start),
        .busy        (busy),
        .func        (func),
        .key_tag     (key_tag),
        .put_value   (put_value),
        .done        (done),
        .hit         (hit),
        .read_value  (read_value),
        .evicted     (evicted),
        .evicted_key (evicted_key)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // Result monitor: done marks a word valid for exactly one cycle, so it
    // is taken at the edge that closes that cycle (pre-edge values).
    always @(posedge clk)
    begin
        if (rst_n && done)
            sb.check_result(hit, read_value, evicted, evicted_key);
    end

    // Watchdog: any accept or result word resets the idle count.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || done)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("timeout: no activity for %0d cycles", IDLE_LIMIT);
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    // Send one word after a random gap. Start is left high on return so
    // that a zero gap on the next word keeps it high without a dip; only
    // one nonblocking write to start happens per time step.
    task automatic issue_word(logic f, logic [63:0] k, logic [31:0] v);
        int gap;
        gap = $urandom_range(0, 10);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start     <= 1'b1;
        func      <= f;
        key_tag   <= k;
        put_value <= v;
        // Accepted at the first edge that sees start high and busy low
        do
            @(posedge clk);
        while (busy);
        sb.note_input(f, k, v);
        words_sent++;
    endtask

    // Drain all results, let the pipeline settle, then write the limit.
    task automatic write_limit(logic [3:0] value);
        start <= 1'b0;
        while (sb.outstanding() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        sb.set_limit(value);
        limit_writes++;
    endtask

    // Mostly pool keys so gets hit and puts update; the rest is noise.
    function automatic logic [63:0] pick_key();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 85)
            return key_pool[$urandom_range(0, POOL_SIZE - 1)];
        else if (roll < 88)
            return '0;
        else if (roll < 91)
            return '1;
        else
            return {$urandom, $urandom};
    endfunction

    initial
    begin
        logic [3:0] limit_plan [10];
        logic       f;

        // 8 then 2 exercises a limit dropped below the current occupancy
        limit_plan = '{4'd8, 4'd2, 4'd0, 4'd15, 4'd1, 4'd9, 4'd3, 4'd8, 4'd6, 4'd4};

        sb           = new();
        idle_cycles  = 0;
        words_sent   = 0;
        limit_writes = 0;
        rst_n        = 1'b0;
        cfg_wr_en    = 1'b0;
        cfg_wr_data  = '0;
        start        = 1'b0;
        func         = FUNC_GET;
        key_tag      = '0;
        put_value    = '0;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed words at the reset limit of five entries
        issue_word(FUNC_GET, 64'h0, 32'hFFFF_FFFF);              // miss on empty cache
        issue_word(FUNC_PUT, 64'h0, 32'hFFFF_FFFF);
        issue_word(FUNC_GET, 64'h0, 32'h0);
        issue_word(FUNC_PUT, 64'hFFFF_FFFF_FFFF_FFFF, 32'h0);
        issue_word(FUNC_GET, 64'hFFFF_FFFF_FFFF_FFFF, 32'h5555_5555);
        issue_word(FUNC_PUT, 64'h0, 32'h1234_5678);              // put hit: value update
        issue_word(FUNC_GET, 64'h0, 32'h0);
        issue_word(FUNC_PUT, 64'h0123_4567_89AB_CDEF, 32'hA5A5_A5A5);
        issue_word(FUNC_PUT, 64'hFEDC_BA98_7654_3210, 32'h5A5A_5A5A);
        issue_word(FUNC_PUT, 64'h8000_0000_0000_0001, 32'h8000_0001);
        issue_word(FUNC_PUT, 64'h7FFF_FFFF_FFFF_FFFE, 32'h7FFF_FFFE); // full: evicts LRU
        issue_word(FUNC_GET, 64'hFFFF_FFFF_FFFF_FFFF, 32'h0);    // evicted key misses
        issue_word(FUNC_GET, 64'h0123_4567_89AB_CDEF, 32'h0);    // promote
        issue_word(FUNC_PUT, 64'h5555_AAAA_5555_AAAA, 32'hDEAD_BEEF);
        issue_word(FUNC_GET, 64'hA5A5_A5A5_A5A5_A5A5, 32'h0);    // get miss on full cache
        issue_word(FUNC_PUT, 64'h0123_4567_89AB_CDEF, 32'hFFFF_FFFF);
        issue_word(FUNC_GET, 64'h0123_4567_89AB_CDEF, 32'h0);

        // Random phases, one per limit setting
        foreach (limit_plan[p])
        begin
            write_limit(limit_plan[p]);
            foreach (key_pool[i])
                key_pool[i] = {$urandom, $urandom};
            // Keep part of the old pool so entries from before the limit
            // change are still hit and evicted
            if (p > 0)
                key_pool[0] = 64'h0123_4567_89AB_CDEF;
            repeat (PHASE_WORDS)
            begin
                f = ($urandom_range(0, 1) == 1) ? FUNC_PUT : FUNC_GET;
                issue_word(f, pick_key(), $urandom);
            end
        end

        start <= 1'b0;
        while (sb.outstanding() != 0)
            @(posedge clk);
        repeat (5) @(posedge clk);

        $display("covered %0d words over %0d limit settings: %0d hits, %0d evictions",
                 words_sent, limit_writes, sb.hits_seen, sb.evictions_seen);
        $display("%0d result words checked, %0d mismatches", sb.words_checked, sb.errors);
        if (sb.errors == 0 && sb.outstanding() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

/* lru_key_value_cache_top.f */
rtl/core/lkvc_pkg.sv
rtl/core/lkvc_cell.sv
rtl/core/lru_key_value_cache_top.sv
dv/tb.sv
